// File: hdl/rcfp_pkg.sv
// shared types and constants for the rc channel frame parser
package rcfp_pkg;

    // parse phase of the byte stream
    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SKIP  = 2'd1,
        PH_STORE = 2'd2
    } t_phase;

    // control sequencer: parsing bytes or reading out the channel store
    typedef enum logic [1:0] {
        ST_PARSE = 2'd0,
        ST_READ  = 2'd1,
        ST_SEND  = 2'd2
    } t_state;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_SYNC_WORD    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SWITCH_THR   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_FIRST_SWITCH = 2'd2;

    localparam logic [15:0] RST_SYNC_WORD    = 16'h4020;
    localparam logic [15:0] RST_SWITCH_THR   = 16'd1900;
    localparam logic [3:0]  RST_FIRST_SWITCH = 4'd6;

    localparam int IN_DW  = 8;
    localparam int OUT_DW = 24;

endpackage

// File: hdl/rc_channel_frame_parser_core.sv
// rc channel frame parser: sync hunt, channel store in ram, per-channel readout
// While parsing, the block takes one received byte per cycle and writes each completed
// channel word into a CHANNELS-deep ram. When the final channel word of a frame arrives,
// input is held off and the ram is read out in order: each channel takes a registered ram
// read (ST_READ) and then a load of the output register (ST_SEND), so a frame end keeps
// the input stalled for the whole readout of all channels plus any output back-pressure. The
// output register lets the last channel wait for the sink while new bytes are taken.
// The ram needs no clearing after reset, since every entry is written before it is read.
module rc_channel_frame_parser_core #(
    parameter int CHANNELS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [rcfp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [rcfp_pkg::CFG_DW-1:0] i_cfg_wdata,
    // byte stream in
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rcfp_pkg::IN_DW-1:0]  s_axis_tdata,   // [7:0] rx_byte
    // channel words out
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [3:0] channel_index, [19:4] channel_value, [20] switch_present,
    // [21] switch_pressed, [23:22] zero
    output logic [rcfp_pkg::OUT_DW-1:0] m_axis_tdata,
    output logic                        m_axis_tlast     // last_of_frame
);
    import rcfp_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

    logic [15:0]   r_sync_word;
    logic [15:0]   r_switch_thr;
    logic [3:0]    r_first_switch;

    logic [15:0]   r_window;
    t_phase        r_phase, n_phase;
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;

    logic          r_m_valid, n_m_valid;
    logic [OUT_DW-1:0] r_m_data, n_m_data;
    logic          r_m_last, n_m_last;

    logic          w_in_acc;
    logic [15:0]   w_window;
    logic          w_ram_we;
    logic          w_ram_re;
    logic [15:0]   w_ram_rdata;
    logic          w_out_free;
    logic [3:0]    w_ch_index;
    logic          w_sw_present;
    logic          w_sw_pressed;

    assign s_axis_tready = (r_state == ST_PARSE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_window      = {s_axis_tdata, r_window[15:8]};
    assign w_ram_we      = w_in_acc && (r_phase == PH_STORE);
    assign w_ram_re      = (r_state == ST_READ);
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign w_ch_index    = 4'(r_idx);
    assign w_sw_present  = (w_ch_index >= r_first_switch);
    assign w_sw_pressed  = w_sw_present && (w_ram_rdata > r_switch_thr);

    rcfp_ram #(
        .WIDTH (16),
        .DEPTH (CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count),
        .i_wdata (w_window),
        .i_re    (w_ram_re),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word    <= RST_SYNC_WORD;
            r_switch_thr   <= RST_SWITCH_THR;
            r_first_switch <= RST_FIRST_SWITCH;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SYNC_WORD:    r_sync_word    <= i_cfg_wdata;
                CFG_SWITCH_THR:   r_switch_thr   <= i_cfg_wdata;
                CFG_FIRST_SWITCH: r_first_switch <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= '0;
            r_phase   <= PH_HUNT;
            r_state   <= ST_PARSE;
            r_count   <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_window <= w_window;
            end
            r_phase   <= n_phase;
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
    end

    always_comb begin
        n_phase   = r_phase;
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;

        case (r_state)
            ST_PARSE: begin
                if (w_in_acc) begin
                    case (r_phase)
                        PH_SKIP: begin
                            n_phase = PH_STORE;
                        end
                        PH_STORE: begin
                            if (r_count == LAST_CH) begin
                                n_count = '0;
                                n_phase = PH_HUNT;
                                n_idx   = '0;
                                n_state = ST_READ;
                            end else begin
                                n_count = r_count + 1'b1;
                                n_phase = PH_SKIP;
                            end
                        end
                        default: begin
                            // hunting, and the unused phase code
                            n_phase = (w_window == r_sync_word) ? PH_SKIP : PH_HUNT;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {2'b00, w_sw_pressed, w_sw_present, w_ram_rdata,
                                 w_ch_index};
                    n_m_last  = (r_idx == LAST_CH);
                    if (r_idx == LAST_CH) begin
                        n_state = ST_PARSE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_PARSE;
            end
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    // final channel word of a frame starts readout at channel zero
    a_frame_end_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_phase == PH_STORE && r_count == LAST_CH)
        |=> (r_state == ST_READ && r_idx == '0))
        else $error("frame end did not start readout");

    // a ram read is always followed by a send cycle with the data
    a_read_then_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |=> (r_state == ST_SEND))
        else $error("ram read not followed by send");

    // the marked word carries the last channel index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[3:0] == 4'(CHANNELS - 1)))
        else $error("last marker on wrong channel");

    // no store write while the ram is being read out
    a_no_write_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_PARSE) |-> !w_ram_we)
        else $error("store written during readout");

endmodule

// File: hdl/rcfp_ram.sv
// generic single-write, single-read ram with registered read data
module rcfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
